// ----- design/queue_with_middle_insert_core_defines.svh -----
// Assertion macros shared by the checker of the middle-insert queue.
// No dependencies; included by the files that assert.
`ifndef QUEUE_WITH_MIDDLE_INSERT_CORE_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QMI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/qmi_pkg.sv -----
// Types, codes and index helpers for the middle-insert queue.
// No dependencies; imported by every module of the block except qmi_ram.
package qmi_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped;
      logic [STATUS_W-1:0]       status;
      cnt_type                   count;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic commit;
   } ctrl_type;

   function automatic idx_type wrap_add(idx_type a, cnt_type b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s >= SUM_W'(CAPACITY)) begin
         s = s - SUM_W'(CAPACITY);
      end
      return IDX_W'(s);
   endfunction

   function automatic idx_type wrap_dec(idx_type a);
      return (a == '0) ? IDX_W'(CAPACITY - 1) : a - idx_type'(1);
   endfunction

endpackage

// ----- design/qmi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qmi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/qmi_ctrl.sv -----
// Controller of the middle-insert queue: item sequencing and result valid.
// Depends on qmi_pkg.
module qmi_ctrl import qmi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_ready;
      req_ready      = (state_ff == S_IDLE);
      ctrl.load_item = req_valid && req_ready;
      ctrl.commit    = (state_ff == S_EXEC) && out_free;
      state_in       = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.load_item) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (ctrl.commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/qmi_datapath.sv -----
// Datapath of the middle-insert queue: ring pointers, both ring RAMs, result register.
// Depends on qmi_pkg and qmi_ram.
module qmi_datapath import qmi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  req_type  req_data,
   output rsp_type  rsp_data
);

   req_type item_ff;
   rsp_type rsp_ff, res;
   idx_type front_start_ff, front_start_in;
   idx_type back_start_ff, back_start_in;
   cnt_type front_fill_ff, front_fill_in;
   cnt_type back_fill_ff, back_fill_in;

   logic               front_we, back_we;
   idx_type            front_wa, back_wa;
   logic [VALUE_W-1:0] front_wd, back_wd;
   logic [VALUE_W-1:0] front_rdata, back_rdata;
   cnt_type            total;
   logic               n_even, is_full, is_empty;

   always_comb begin
      total    = front_fill_ff + back_fill_ff;
      n_even   = ~total[0];
      is_full  = (total >= cnt_type'(CAPACITY));
      is_empty = (total == '0);

      front_start_in = front_start_ff;
      back_start_in  = back_start_ff;
      front_fill_in  = front_fill_ff;
      back_fill_in   = back_fill_ff;
      front_we       = 1'b0;
      back_we        = 1'b0;
      front_wa       = wrap_add(front_start_ff, front_fill_ff);
      back_wa        = wrap_add(back_start_ff, back_fill_ff);
      front_wd       = item_ff.value;
      back_wd        = item_ff.value;
      res.popped     = '0;
      res.status     = STATUS_OK;
      res.count      = total;

      case (item_ff.cmd)
         CMD_PUSH, CMD_INSERT: begin
            if (is_full) begin
               res.status = STATUS_FULL;
            end else begin
               res.count = total + cnt_type'(1);
               if (n_even) begin
                  front_we      = 1'b1;
                  front_fill_in = front_fill_ff + cnt_type'(1);
                  if (item_ff.cmd == CMD_PUSH && !is_empty) begin
                     front_wd      = back_rdata;
                     back_we       = 1'b1;
                     back_start_in = wrap_add(back_start_ff, cnt_type'(1));
                  end
               end else begin
                  back_we      = 1'b1;
                  back_fill_in = back_fill_ff + cnt_type'(1);
                  if (item_ff.cmd == CMD_INSERT) begin
                     back_wa       = wrap_dec(back_start_ff);
                     back_start_in = back_wa;
                  end
               end
            end
         end
         CMD_POP: begin
            if (is_empty) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.popped     = front_rdata;
               res.count      = total - cnt_type'(1);
               front_start_in = wrap_add(front_start_ff, cnt_type'(1));
               if (n_even) begin
                  front_we      = 1'b1;
                  front_wd      = back_rdata;
                  back_start_in = wrap_add(back_start_ff, cnt_type'(1));
                  back_fill_in  = back_fill_ff - cnt_type'(1);
               end else begin
                  front_fill_in = front_fill_ff - cnt_type'(1);
               end
            end
         end
         default: res.status = STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_start_ff <= '0;
         back_start_ff  <= '0;
         front_fill_ff  <= '0;
         back_fill_ff   <= '0;
      end else if (ctrl.commit) begin
         front_start_ff <= front_start_in;
         back_start_ff  <= back_start_in;
         front_fill_ff  <= front_fill_in;
         back_fill_ff   <= back_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         item_ff <= req_data;
      end
      if (ctrl.commit) begin
         rsp_ff <= res;
      end
   end

   qmi_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_front_ring (
      .clock   (clock),
      .wr_en   (front_we && ctrl.commit),
      .wr_addr (front_wa),
      .wr_data (front_wd),
      .rd_addr (front_start_ff),
      .rd_data (front_rdata)
   );

   qmi_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_back_ring (
      .clock   (clock),
      .wr_en   (back_we && ctrl.commit),
      .wr_addr (back_wa),
      .wr_data (back_wd),
      .rd_addr (back_start_ff),
      .rd_data (back_rdata)
   );

   assign rsp_data = rsp_ff;

endmodule

// ----- design/queue_with_middle_insert_core.sv -----
// Bounded queue of signed 32-bit values with push at the back, insertion at the
// middle and pop at the front; each item returns one result with the popped
// value, a status and the new count. An item is accepted in the idle state and
// completed in the execute state, because both ring RAMs present their head
// entries through a registered read port that is consumed in the cycle of the
// write-back; ready stays low from each accepted item until it completes.
// The result waits in an output register, so the next item can be accepted
// while an earlier result is still pending; that item completes only once the
// output register is free. Depends on qmi_pkg, qmi_ctrl and qmi_datapath.
module queue_with_middle_insert_core import qmi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_type ctrl;

   qmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   qmi_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- design/qmi_checker.sv -----
// Port-level checker for the middle-insert queue and its bind to the top level.
// Depends on qmi_pkg and queue_with_middle_insert_core_defines.svh.
`include "queue_with_middle_insert_core_defines.svh"

module qmi_checker import qmi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `QMI_ASSERT_NOW(a_full_count, clock, reset,
      rsp_valid && rsp_data.status == STATUS_FULL,
      rsp_data.count == cnt_type'(CAPACITY) && rsp_data.popped == '0,
      "Full status without a full queue.")
   `QMI_ASSERT_NOW(a_empty_count, clock, reset,
      rsp_valid && rsp_data.status == STATUS_EMPTY,
      rsp_data.count == '0 && rsp_data.popped == '0,
      "Empty status with values held.")
   `QMI_ASSERT_NOW(a_count_bound, clock, reset,
      rsp_valid,
      rsp_data.count <= cnt_type'(CAPACITY),
      "Count beyond capacity.")
   `QMI_ASSERT_NEXT(a_one_item, clock, reset,
      req_valid && req_ready,
      !req_ready,
      "Item accepted while another is in flight.")

endmodule

bind queue_with_middle_insert_core qmi_checker u_qmi_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for queue_with_middle_insert_core: push, middle insertion
// and pop traffic plus unused codes, with random gaps and stalls on both channels, is checked against
// an in-order model of the held values. Depends on qmi_pkg and the RTL of the block.
module tb_top import qmi_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
   localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7fff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type                   pending_items[$];
   rsp_type                   awaited_results[$];
   logic signed [VALUE_W-1:0] held_values[$];
   int unsigned               planned_count = 0;
   int unsigned               req_gap = 0;
   int unsigned               rsp_hold = 0;
   bit                        req_burst = 1'b0;
   bit                        rsp_burst = 1'b0;
   int unsigned               mismatches = 0;

   queue_with_middle_insert_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the held values and returns the result it must produce.
   function automatic rsp_type apply_command(req_type item);
      rsp_type     result;
      int unsigned n;
      result = '0;
      n = held_values.size();
      case (item.cmd)
         CMD_PUSH, CMD_INSERT: begin
            if (n >= CAPACITY) begin
               result.status = STATUS_FULL;
            end else if (item.cmd == CMD_PUSH) begin
               held_values.insert(int'(n), item.value);
            end else begin
               held_values.insert(int'((n + 1) / 2), item.value);
            end
         end
         CMD_POP: begin
            if (n == 0) begin
               result.status = STATUS_EMPTY;
            end else begin
               result.popped = held_values[0];
               held_values.delete(0);
            end
         end
         default: begin
         end
      endcase
      result.count = cnt_type'(held_values.size());
      return result;
   endfunction

   task automatic plan_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      req_type item;
      item.cmd = cmd;
      item.value = value;
      pending_items.insert(pending_items.size(), item);
      if ((cmd == CMD_PUSH || cmd == CMD_INSERT) && planned_count < CAPACITY) begin
         planned_count++;
      end else if (cmd == CMD_POP && planned_count > 0) begin
         planned_count--;
      end
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Weights in percent: pop, unused code; the rest split between insert and push.
   function automatic logic [CMD_W-1:0] pick_command(int unsigned pop_pct,
                                                      int unsigned unused_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
         return CMD_POP;
      end else if (r < pop_pct + unused_pct) begin
         return CMD_UNUSED;
      end else if (r[0]) begin
         return CMD_INSERT;
      end
      return CMD_PUSH;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.insert(awaited_results.size(), apply_command(req_data));
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data <= pending_items[0];
               pending_items.delete(0);
               req_valid <= 1'b1;
               if ($urandom_range(0, 63) == 0) begin
                  req_burst = !req_burst;
               end
               req_gap = req_burst ? 0 : $urandom_range(0, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         rsp_hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: popped %0d, status %0d, count %0d",
                      rsp_data.popped, rsp_data.status, rsp_data.count);
               mismatches++;
            end else begin
               wanted = awaited_results[0];
               awaited_results.delete(0);
               if (rsp_data.popped !== wanted.popped) begin
                  $error("popped: expected %0d, actual %0d", wanted.popped, rsp_data.popped);
                  mismatches++;
               end
               if (rsp_data.status !== wanted.status) begin
                  $error("status: expected %0d, actual %0d", wanted.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.count !== wanted.count) begin
                  $error("count: expected %0d, actual %0d", wanted.count, rsp_data.count);
                  mismatches++;
               end
            end
            if ($urandom_range(0, 63) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 7);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   initial begin
      logic [CMD_W-1:0] cmd;
      // Directed opening: empty pop, unused code, extremes, and a drain past empty.
      plan_command(CMD_POP, VALUE_MAX);
      plan_command(CMD_UNUSED, '1);
      plan_command(CMD_INSERT, VALUE_MIN);
      plan_command(CMD_PUSH, VALUE_MAX);
      plan_command(CMD_INSERT, '0);
      plan_command(CMD_PUSH, '1);
      plan_command(CMD_INSERT, 32'h5555_5555);
      plan_command(CMD_UNUSED, 32'haaaa_aaaa);
      plan_command(CMD_PUSH, 32'haaaa_aaaa);
      repeat (7) plan_command(CMD_POP, '0);
      plan_command(CMD_PUSH, 32'h0000_0001);
      plan_command(CMD_INSERT, 32'hffff_fffe);
      plan_command(CMD_INSERT, VALUE_MAX);
      plan_command(CMD_POP, '1);

      // Mixed traffic that lets the queue grow slowly.
      repeat (480) begin
         plan_command(pick_command(40, 4), pick_value());
      end

      // Drain past empty.
      while (planned_count > 0) begin
         cmd = pick_command(85, 1);
         plan_command(cmd, pick_value());
      end
      repeat (3) plan_command(CMD_POP, pick_value());
      plan_command(CMD_INSERT, pick_value());
      plan_command(CMD_POP, pick_value());

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
